// ===== src/sef_pkg.sv =====
// Shared types and constants for the sparse element filter.
`timescale 1ns / 1ps
`default_nettype none

package sef_pkg;

  localparam int VALUE_W    = 32;
  localparam int ELEM_W     = 16;
  localparam int INDEX_W    = 8;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Filter kinds; the spare code behaves as the isolation filter.
  localparam logic [1:0] FILT_EVEN     = 2'd0;
  localparam logic [1:0] FILT_UNIQUE   = 2'd1;
  localparam logic [1:0] FILT_ISOLATED = 2'd2;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Register word index on the configuration port.
  localparam logic [0:0] REG_FILTER_SELECT = 1'b0;

  typedef struct packed {
    logic                      mode;
    logic                      restart;
    logic [ELEM_W-1:0]         elem_row;
    logic [ELEM_W-1:0]         elem_col;
    logic signed [VALUE_W-1:0] elem_value;
    logic [INDEX_W-1:0]        query_index;
  } in_item_t;

  typedef struct packed {
    logic [INDEX_W-1:0] result_index;
    logic               keep;
    logic               error;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REF_RD,
    ST_REF_CAP,
    ST_SCAN,
    ST_FINISH,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic take;
    logic ref_rd;
    logic ref_cap;
    logic scan_step;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic load_full;
    logic query_bad;
    logic count_one;
    logic scan_last;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== src/sef_ctrl.sv =====
// Controller state machine sequencing loads, queries and the table scan.
`timescale 1ns / 1ps
`default_nettype none

module sef_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                in_mode,
  input  wire logic [1:0]          filter_sel,
  input  wire sef_pkg::dp_status_t status,
  output logic                     in_ready,
  output sef_pkg::ctrl_cmd_t       cmd,
  output sef_pkg::state_t          state
);

  sef_pkg::state_t state_r;
  sef_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sef_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sef_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_mode == sef_pkg::MODE_LOAD) begin
            state_nxt = status.load_full ? sef_pkg::ST_EMIT : sef_pkg::ST_IDLE;
          end else begin
            state_nxt = status.query_bad ? sef_pkg::ST_EMIT : sef_pkg::ST_REF_RD;
          end
        end
      end
      sef_pkg::ST_REF_RD: begin
        state_nxt = sef_pkg::ST_REF_CAP;
      end
      sef_pkg::ST_REF_CAP: begin
        if (filter_sel == sef_pkg::FILT_EVEN) begin
          state_nxt = sef_pkg::ST_EMIT;
        end else if (status.count_one) begin
          state_nxt = sef_pkg::ST_FINISH;
        end else begin
          state_nxt = sef_pkg::ST_SCAN;
        end
      end
      sef_pkg::ST_SCAN: begin
        if (status.scan_last) begin
          state_nxt = sef_pkg::ST_FINISH;
        end
      end
      sef_pkg::ST_FINISH: begin
        state_nxt = sef_pkg::ST_EMIT;
      end
      sef_pkg::ST_EMIT: begin
        if (status.out_free) begin
          state_nxt = sef_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sef_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready      = (state_r == sef_pkg::ST_IDLE);
    cmd.take      = (state_r == sef_pkg::ST_IDLE) && in_valid;
    cmd.ref_rd    = (state_r == sef_pkg::ST_REF_RD);
    cmd.ref_cap   = (state_r == sef_pkg::ST_REF_CAP);
    cmd.scan_step = (state_r == sef_pkg::ST_SCAN);
    cmd.emit      = (state_r == sef_pkg::ST_EMIT) && status.out_free;
  end

  assign state = state_r;

endmodule

`default_nettype wire

// ===== src/sef_dp.sv =====
// Datapath: element memory, stored count, scan comparators and result register.
`timescale 1ns / 1ps
`default_nettype none

module sef_dp #(
  parameter int MAX_ELEMENTS = 256,
  parameter int COORD_WIDTH  = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire sef_pkg::ctrl_cmd_t cmd,
  input  wire logic [1:0]         filter_sel,
  input  wire sef_pkg::in_item_t  in_data,
  output sef_pkg::dp_status_t     status,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output sef_pkg::out_item_t      out_data
);

  localparam int CW      = (COORD_WIDTH < sef_pkg::ELEM_W) ? COORD_WIDTH : sef_pkg::ELEM_W;
  localparam int AW      = $clog2(MAX_ELEMENTS);
  localparam int CNTW    = $clog2(MAX_ELEMENTS + 1);
  localparam int CMPW    = (CNTW > sef_pkg::INDEX_W) ? CNTW : sef_pkg::INDEX_W;
  localparam int ENTRY_W = sef_pkg::VALUE_W + 2 * CW;

  // Entry layout: value above column above row.
  logic [ENTRY_W-1:0] mem [MAX_ELEMENTS];
  logic [ENTRY_W-1:0] rd_data_r;
  logic [ENTRY_W-1:0] ref_r;
  logic [ENTRY_W-1:0] wr_data;
  logic [AW-1:0]      wr_addr;
  logic [AW-1:0]      rd_addr;
  logic               wr_en;

  logic [CNTW-1:0]            count_r;
  logic [CNTW-1:0]            count_nxt;
  logic [sef_pkg::INDEX_W-1:0] qidx_r;
  logic [sef_pkg::INDEX_W-1:0] res_idx_r;
  logic                        err_r;
  logic [AW-1:0]               scan_addr_r;
  logic                        cmp_vld_r;
  logic [1:0]                  hits_r;
  logic                        nbr_r;
  logic                        out_valid_r;
  sef_pkg::out_item_t          out_data_r;

  logic [CMPW-1:0] qidx_in_ext;
  logic [CMPW-1:0] qidx_r_ext;
  logic [CMPW-1:0] count_ext;
  logic            is_load;
  logic            load_full;

  logic [CW-1:0]               rd_row, rd_col, ref_row, ref_col;
  logic [sef_pkg::VALUE_W-1:0] rd_val, ref_val;
  logic                        same_val, same_pos, near_row, near_col, nbr_hit;
  logic                        keep;

  assign qidx_in_ext = CMPW'(in_data.query_index);
  assign qidx_r_ext  = CMPW'(qidx_r);
  assign count_ext   = CMPW'(count_r);
  assign is_load     = (in_data.mode == sef_pkg::MODE_LOAD);
  assign load_full   = !in_data.restart && (count_r >= CNTW'(MAX_ELEMENTS));

  assign status.load_full = load_full;
  assign status.query_bad = (qidx_in_ext >= count_ext);
  assign status.count_one = (count_r == CNTW'(1));
  assign status.scan_last = (CNTW'(scan_addr_r) == (count_r - CNTW'(1)));
  assign status.out_free  = !out_valid_r || out_ready;

  // Table write on an accepted load that finds room.
  assign wr_en     = cmd.take && is_load && !load_full;
  assign wr_addr   = in_data.restart ? '0 : count_r[AW-1:0];
  assign wr_data   = {in_data.elem_value, in_data.elem_col[CW-1:0], in_data.elem_row[CW-1:0]};
  assign count_nxt = in_data.restart ? CNTW'(1) : (count_r + CNTW'(1));

  always_comb begin
    if (cmd.ref_rd) begin
      rd_addr = qidx_r_ext[AW-1:0];
    end else if (cmd.ref_cap) begin
      rd_addr = '0;
    end else begin
      rd_addr = scan_addr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_row  = rd_data_r[CW-1:0];
  assign rd_col  = rd_data_r[2*CW-1:CW];
  assign rd_val  = rd_data_r[ENTRY_W-1:2*CW];
  assign ref_row = ref_r[CW-1:0];
  assign ref_col = ref_r[2*CW-1:CW];
  assign ref_val = ref_r[ENTRY_W-1:2*CW];

  // Coordinates are compared one bit wider so that the edges never wrap.
  assign same_val = (rd_val == ref_val);
  assign same_pos = (rd_row == ref_row) && (rd_col == ref_col);
  assign near_row = (rd_row == ref_row)
                 || ({1'b0, rd_row} == ({1'b0, ref_row} + (CW+1)'(1)))
                 || ({1'b0, ref_row} == ({1'b0, rd_row} + (CW+1)'(1)));
  assign near_col = (rd_col == ref_col)
                 || ({1'b0, rd_col} == ({1'b0, ref_col} + (CW+1)'(1)))
                 || ({1'b0, ref_col} == ({1'b0, rd_col} + (CW+1)'(1)));
  assign nbr_hit  = !same_pos && near_row && near_col;

  always_comb begin
    if (err_r) begin
      keep = 1'b0;
    end else begin
      case (filter_sel)
        sef_pkg::FILT_EVEN:   keep = !ref_val[0];
        sef_pkg::FILT_UNIQUE: keep = (hits_r == 2'd1);
        default:              keep = !nbr_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        count_r <= count_nxt;
      end
      cmp_vld_r <= cmd.ref_cap || cmd.scan_step;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      if (is_load) begin
        res_idx_r <= '0;
        err_r     <= load_full;
      end else begin
        qidx_r    <= in_data.query_index;
        res_idx_r <= in_data.query_index;
        err_r     <= status.query_bad;
      end
    end
    if (cmd.ref_cap) begin
      ref_r       <= rd_data_r;
      scan_addr_r <= AW'(1);
      hits_r      <= 2'd0;
      nbr_r       <= 1'b0;
    end else begin
      if (cmd.scan_step) begin
        scan_addr_r <= scan_addr_r + AW'(1);
      end
      if (cmp_vld_r) begin
        if (same_val && (hits_r != 2'd2)) begin
          hits_r <= hits_r + 2'd1;
        end
        if (nbr_hit) begin
          nbr_r <= 1'b1;
        end
      end
    end
    if (cmd.emit) begin
      out_data_r.result_index <= res_idx_r;
      out_data_r.keep         <= keep;
      out_data_r.error        <= err_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== src/sparse_element_filter_unit.sv =====
// Top level of the sparse element filter: configuration port, controller and datapath.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Ports                               Beat carries
// input     in         in_valid, in_ready, in_data          one load or query item
// result    out        out_valid, out_ready, out_data       index echo, keep, error
// config    in/out     psel, penable, pwrite, paddr,        filter select register
//                      pwdata, prdata, pready
//
// A load leaves the block ready again at once; a load into a full table and a
// query past the stored count go straight to the emit state. An even-value query
// reads and captures its reference entry, then emits; a unique or isolated query
// also scans the table through the single read port of the element memory.
// Reset is synchronous and clears only the count, the register and the control and
// handshake state; the memory needs no clearing pass. A result waits in the output
// register while the next item is accepted; only a second result stalls the block.

module sparse_element_filter_unit #(
  parameter int MAX_ELEMENTS = 256,
  parameter int COORD_WIDTH  = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire sef_pkg::in_item_t                  in_data,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output sef_pkg::out_item_t                      out_data,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [sef_pkg::CFG_ADDR_W-1:0]     paddr,
  input  wire logic [sef_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [sef_pkg::CFG_DATA_W-1:0]          prdata,
  output logic                                    pready
);

  logic [1:0]          filter_r;
  logic [0:0]          cfg_idx;
  logic                cfg_wr;
  sef_pkg::ctrl_cmd_t  cmd;
  sef_pkg::dp_status_t status;
  sef_pkg::state_t     ctrl_state;

  // Registers sit on 32-bit words, so the word index is the address above the byte lane.
  assign cfg_idx = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_r <= sef_pkg::FILT_EVEN;
    end else if (cfg_wr && (cfg_idx == sef_pkg::REG_FILTER_SELECT)) begin
      filter_r <= pwdata[1:0];
    end
  end

  always_comb begin
    if (cfg_idx == sef_pkg::REG_FILTER_SELECT) begin
      prdata = {{(sef_pkg::CFG_DATA_W-2){1'b0}}, filter_r};
    end else begin
      prdata = '0;
    end
  end

  sef_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_mode    (in_data.mode),
    .filter_sel (filter_r),
    .status     (status),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .state      (ctrl_state)
  );

  sef_dp #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .COORD_WIDTH  (COORD_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .filter_sel (filter_r),
    .in_data    (in_data),
    .status     (status),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .out_data   (out_data)
  );

  // An accepted query always leaves the block busy, so it is not ready for a new item.
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.mode == sef_pkg::MODE_QUERY) |=> !in_ready)
    else $error("query beat did not make the block busy");

  // A load with restart can never fail, so the block stays ready.
  a_restart_ok: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.mode == sef_pkg::MODE_LOAD) && in_data.restart
    |=> in_ready)
    else $error("restart load did not complete in one cycle");

  // A result appears only after the controller sat in its emit state.
  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(ctrl_state == sef_pkg::ST_EMIT))
    else $error("result raised outside the emit state");

  // A write to the filter register takes effect on the next cycle.
  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr && (cfg_idx == sef_pkg::REG_FILTER_SELECT) |=> filter_r == $past(pwdata[1:0]))
    else $error("filter select write lost");

endmodule

`default_nettype wire
